/* rtl/tcd_pkg.sv */
// ----------------------------------------------------------------------------
// tcd_pkg
// Codes and types for the text control code decoder: parse phases, lead
// bytes, token codes, result kinds and the result record.
// ----------------------------------------------------------------------------
package tcd_pkg;

   localparam int PHASE_W = 3;

   localparam logic [PHASE_W-1:0] PH_LEAD   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_ARG1   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_ARG2   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_IDX_HI = 3'd3;
   localparam logic [PHASE_W-1:0] PH_IDX_LO = 3'd4;

   localparam logic [7:0] LEAD_END    = 8'h00;
   localparam logic [7:0] LEAD_SELECT = 8'h01;
   localparam logic [7:0] LEAD_MODE   = 8'h02;
   localparam logic [7:0] LEAD_WORD   = 8'h03;
   localparam logic [7:0] LEAD_CTRL   = 8'h04;
   localparam logic [7:0] LEAD_VALUE  = 8'h05;
   localparam logic [7:0] LEAD_PUSH   = 8'h06;
   localparam logic [7:0] LEAD_JUMP   = 8'h07;
   localparam logic [7:0] LEAD_ARG8   = 8'h08;
   localparam logic [7:0] LEAD_ARG9   = 8'h09;
   localparam logic [7:0] LEAD_BREAK  = 8'h0A;
   localparam logic [7:0] LEAD_PAGE_B = 8'h0B;
   localparam logic [7:0] LEAD_PAGE_C = 8'h0C;
   localparam logic [7:0] LEAD_PAGE_D = 8'h0D;
   localparam logic [7:0] LEAD_PAGE_E = 8'h0E;
   localparam logic [7:0] LEAD_PAGE_F = 8'h0F;
   localparam logic [7:0] GLYPH_MIN   = 8'h10;

   localparam logic [7:0] ARG_NONE     = 8'hFF;
   localparam logic [7:0] ARG_NEXT     = 8'h10;
   localparam logic [7:0] ARG_FLAG_LO  = 8'h14;
   localparam logic [7:0] ARG_FLAG_HI  = 8'h15;
   localparam logic [7:0] ARG_SUB_MAX  = 8'h13;
   localparam logic [7:0] ARG_SUB_BIAS = 8'h0F;
   localparam logic [7:0] ARG_SEL_LIM  = 8'h0B;
   localparam logic [7:0] ARG_SLOT_MAX = 8'h04;
   localparam logic [7:0] ARG_IDX      = 8'h05;

   localparam logic [10:0] CODE_END      = 11'h000;
   localparam logic [10:0] CODE_BREAK    = 11'h001;
   localparam logic [10:0] CODE_CTRL_DEF = 11'h004;
   localparam logic [10:0] CODE_SEL_LO   = 11'h005;
   localparam logic [10:0] CODE_SEL_HI   = 11'h006;
   localparam logic [10:0] CODE_MODE     = 11'h007;
   localparam logic [10:0] CODE_WORD     = 11'h008;
   localparam logic [10:0] CODE_CTRL_LO  = 11'h009;
   localparam logic [10:0] CODE_CTRL_NXT = 11'h00A;
   localparam logic [10:0] CODE_FLAG     = 11'h00B;
   localparam logic [10:0] CODE_VALUE    = 11'h00C;
   localparam logic [10:0] CODE_ARG8     = 11'h00D;
   localparam logic [10:0] CODE_ARG9     = 11'h00E;
   localparam logic [10:0] GLYPH_BASE    = 11'h100;
   localparam logic [10:0] PAGE_B_BASE   = 11'h400;
   localparam logic [10:0] PAGE_C_BASE   = 11'h700;
   localparam logic [10:0] PAGE_D_BASE   = 11'h500;
   localparam logic [10:0] PAGE_E_BASE   = 11'h600;
   localparam logic [10:0] PAGE_F_BASE   = 11'h300;

   localparam logic [2:0] KIND_TOKEN    = 3'd0;
   localparam logic [2:0] KIND_PUSH_VAR = 3'd1;
   localparam logic [2:0] KIND_PUSH_IDX = 3'd2;
   localparam logic [2:0] KIND_JUMP     = 3'd3;
   localparam logic [2:0] KIND_POP      = 3'd4;

   typedef struct packed {
      logic [2:0]  kind;
      logic [10:0] token_code;
      logic [15:0] param_value;
      logic [15:0] aux_value;
      logic [7:0]  lead_byte;
      logic        push_ok;
      logic [2:0]  nest_depth;
   } tcd_rsp_type;

endpackage

/* rtl/text_control_code_decoder.sv */
// ----------------------------------------------------------------------------
// text_control_code_decoder
// Parses text-script bytes into tokens and string stack requests.
//
//   channel | dir | tdata                           | tuser
//   req     | in  | data_byte                       | command
//   rsp     | out | token_code, param_value,        | kind
//           |     | aux_value, lead_byte, push_ok,  |
//           |     | nest_depth                      |
//
// One item per cycle sustained while results are not stalled; a result is
// registered from its item in the input register into the result register.
// The parse state and stack depth update in the decode stage between them.
// Reset is synchronous; afterwards the stack is inactive and every data
// byte decodes as an end token until a new string is started.
// A stalled result holds the decode stage only for items that give a result.
// ----------------------------------------------------------------------------
module text_control_code_decoder
   import tcd_pkg::*;
#(
   parameter int NEST_LEVELS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [10:0] token_code, [26:11] param_value,
                                    // [42:27] aux_value, [50:43] lead_byte,
                                    // [51] push_ok, [54:52] nest_depth, [55] 0
   output logic [2:0]  rsp_tuser    // [2:0] kind
);

   localparam int DEPTH_W = (NEST_LEVELS > 2) ? $clog2(NEST_LEVELS) : 1;
   localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(NEST_LEVELS - 2);

   logic               in_valid_ff;
   logic               in_cmd_ff;
   logic [7:0]         in_byte_ff;

   logic [PHASE_W-1:0] phase_ff,  phase_in;
   logic [7:0]         lead_ff,   lead_in;
   logic [7:0]         arg_ff,    arg_in;
   logic [DEPTH_W-1:0] depth_ff,  depth_in;
   logic               active_ff, active_in;
   logic [15:0]        param_ff,  param_in;

   logic               rsp_valid_ff;
   tcd_rsp_type        rsp_ff, rsp_in;
   logic               emit;
   logic               fire;

   logic               push_ok;
   logic [DEPTH_W-1:0] push_depth;
   logic [7:0]         b;
   logic [15:0]        word;
   logic [DEPTH_W+2:0] depth_wide;

   assign b    = in_byte_ff;
   assign word = {arg_ff, in_byte_ff};

   always_comb begin
      push_ok    = !(active_ff && (depth_ff > DEPTH_FULL));
      push_depth = (active_ff && push_ok) ? depth_ff + DEPTH_W'(1) : depth_ff;
   end

   always_comb begin
      phase_in  = phase_ff;
      lead_in   = lead_ff;
      arg_in    = arg_ff;
      depth_in  = depth_ff;
      active_in = active_ff;
      param_in  = param_ff;
      emit      = 1'b0;
      rsp_in    = '0;
      rsp_in.kind = KIND_TOKEN;

      if (!in_cmd_ff) begin
         phase_in  = PH_LEAD;
         lead_in   = '0;
         arg_in    = '0;
         depth_in  = '0;
         active_in = 1'b1;
         param_in  = '0;
      end else begin
         case (phase_ff)
            PH_LEAD: begin
               if (!active_ff) begin
                  lead_in = LEAD_END;
                  emit    = 1'b1;
                  rsp_in.token_code = CODE_END;
               end else begin
                  lead_in = b;
                  if (b == LEAD_END) begin
                     emit = 1'b1;
                     if (depth_ff != '0) begin
                        depth_in    = depth_ff - DEPTH_W'(1);
                        rsp_in.kind = KIND_POP;
                     end else begin
                        active_in = 1'b0;
                        rsp_in.token_code = CODE_END;
                     end
                  end else if (b == LEAD_BREAK) begin
                     emit = 1'b1;
                     rsp_in.token_code = CODE_BREAK;
                  end else if (b >= GLYPH_MIN) begin
                     emit = 1'b1;
                     rsp_in.token_code = 11'(b) + GLYPH_BASE;
                  end else begin
                     phase_in = PH_ARG1;
                  end
               end
            end
            PH_ARG1: begin
               phase_in = PH_LEAD;
               emit     = 1'b1;
               case (lead_ff)
                  LEAD_SELECT: begin
                     param_in = 16'(b);
                     rsp_in.token_code = (b < ARG_SEL_LIM) ? CODE_SEL_LO : CODE_SEL_HI;
                  end
                  LEAD_MODE: begin
                     param_in = 16'(b);
                     rsp_in.token_code = CODE_MODE;
                  end
                  LEAD_ARG8: begin
                     param_in = 16'(b);
                     rsp_in.token_code = CODE_ARG8;
                  end
                  LEAD_ARG9: begin
                     param_in = 16'(b);
                     rsp_in.token_code = CODE_ARG9;
                  end
                  LEAD_CTRL: begin
                     if (b == ARG_NEXT) begin
                        emit     = 1'b0;
                        arg_in   = b;
                        phase_in = PH_ARG2;
                     end else if (b == ARG_FLAG_LO || b == ARG_FLAG_HI) begin
                        param_in = 16'(b - ARG_FLAG_LO);
                        rsp_in.token_code = CODE_FLAG;
                     end else begin
                        param_in = 16'(b);
                        if (b < GLYPH_MIN) begin
                           rsp_in.token_code = CODE_CTRL_LO;
                        end else if (b <= ARG_SUB_MAX) begin
                           rsp_in.token_code = 11'(b - ARG_SUB_BIAS);
                        end else begin
                           rsp_in.token_code = CODE_CTRL_DEF;
                        end
                     end
                  end
                  LEAD_VALUE: begin
                     if (b == ARG_NONE) begin
                        rsp_in.token_code = CODE_VALUE;
                     end else begin
                        emit     = 1'b0;
                        arg_in   = b;
                        phase_in = PH_ARG2;
                     end
                  end
                  LEAD_PUSH: begin
                     if (b <= ARG_SLOT_MAX) begin
                        depth_in  = push_depth;
                        active_in = 1'b1;
                        rsp_in.kind        = KIND_PUSH_VAR;
                        rsp_in.param_value = 16'(b);
                        rsp_in.lead_byte   = LEAD_PUSH;
                        rsp_in.push_ok     = push_ok;
                     end else begin
                        emit = 1'b0;
                        if (b == ARG_IDX) begin
                           phase_in = PH_IDX_HI;
                        end
                     end
                  end
                  LEAD_PAGE_B: rsp_in.token_code = PAGE_B_BASE | 11'(b);
                  LEAD_PAGE_C: rsp_in.token_code = PAGE_C_BASE | 11'(b);
                  LEAD_PAGE_D: rsp_in.token_code = PAGE_D_BASE | 11'(b);
                  LEAD_PAGE_E: rsp_in.token_code = PAGE_E_BASE | 11'(b);
                  LEAD_PAGE_F: rsp_in.token_code = PAGE_F_BASE | 11'(b);
                  default: begin
                     emit     = 1'b0;
                     arg_in   = b;
                     phase_in = PH_ARG2;
                  end
               endcase
            end
            PH_ARG2: begin
               phase_in = PH_LEAD;
               emit     = 1'b1;
               if (lead_ff == LEAD_WORD) begin
                  param_in = word;
                  rsp_in.token_code = CODE_WORD;
               end else if (lead_ff == LEAD_CTRL) begin
                  param_in = 16'(b);
                  rsp_in.token_code = CODE_CTRL_NXT;
               end else if (lead_ff == LEAD_VALUE) begin
                  rsp_in.token_code = CODE_VALUE;
                  rsp_in.aux_value  = word;
               end else begin
                  depth_in  = '0;
                  active_in = 1'b1;
                  rsp_in.kind        = KIND_JUMP;
                  rsp_in.param_value = word;
                  rsp_in.lead_byte   = LEAD_JUMP;
                  rsp_in.push_ok     = 1'b1;
               end
            end
            PH_IDX_HI: begin
               arg_in   = b;
               phase_in = PH_IDX_LO;
            end
            PH_IDX_LO: begin
               phase_in  = PH_LEAD;
               emit      = 1'b1;
               depth_in  = push_depth;
               active_in = 1'b1;
               rsp_in.kind        = KIND_PUSH_IDX;
               rsp_in.param_value = word;
               rsp_in.lead_byte   = LEAD_PUSH;
               rsp_in.push_ok     = push_ok;
            end
            default: phase_in = PH_LEAD;
         endcase
      end

      if (rsp_in.kind == KIND_TOKEN) begin
         rsp_in.param_value = param_in;
         rsp_in.lead_byte   = lead_in;
      end
      depth_wide        = {3'b000, depth_in};
      rsp_in.nest_depth = depth_wide[2:0];
   end

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready || !emit);
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_cmd_ff  <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LEAD;
         lead_ff   <= '0;
         arg_ff    <= '0;
         depth_ff  <= '0;
         active_ff <= 1'b0;
         param_ff  <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         lead_ff   <= lead_in;
         arg_ff    <= arg_in;
         depth_ff  <= depth_in;
         active_ff <= active_in;
         param_ff  <= param_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fire && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {1'b0, rsp_ff.nest_depth, rsp_ff.push_ok, rsp_ff.lead_byte,
                        rsp_ff.aux_value, rsp_ff.param_value, rsp_ff.token_code};

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(NEST_LEVELS - 1))
      else $error("stack depth beyond nest levels");

   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_IDX_LO)
      else $error("parse phase out of range");

   a_ok_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.push_ok |->
         rsp_ff.kind == KIND_PUSH_VAR || rsp_ff.kind == KIND_PUSH_IDX ||
         rsp_ff.kind == KIND_JUMP)
      else $error("push_ok on a result that is no push");

   a_jump_base: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == KIND_JUMP |->
         rsp_ff.push_ok && rsp_ff.nest_depth == 3'd0)
      else $error("jump not at base of stack");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && emit && rsp_valid_ff && !rsp_tready |=> $stable(phase_ff))
      else $error("decode advanced while result stalled");

endmodule
